/* src/lpsc_pkg.sv */
package lpsc_pkg;

    // Field widths
    localparam int POS_W  = 13;
    localparam int RAD_W  = 15;
    localparam int GRID_W = 11;
    localparam int NRM_W  = 16;
    localparam int CW     = 13;           // clamped grid size, covers the largest MAX_GRID
    localparam int DW     = 14;           // signed offset from the centre
    localparam int AW     = 13;           // magnitude of an offset
    localparam int SQ_W   = 2 * AW;       // one squared offset
    localparam int SW     = SQ_W + 2;     // sum of three squared offsets
    localparam int R2_W   = 2 * RAD_W;    // squared radius

    // Parameter defaults
    localparam int MAX_GRID_DEF     = 1024;
    localparam int NORMAL_FRAC_DEF  = 14;
    localparam int RADIUS_FRAC_DEF  = 4;

    // Register reset values
    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);

    // Register indexes
    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;
    localparam logic [1:0] REG_WALL_Z = 2'd3;

    // Shape kinds
    localparam logic [1:0] KIND_SPHERE = 2'd0;
    localparam logic [1:0] KIND_CYL    = 2'd1;
    localparam logic [1:0] KIND_CHAN   = 2'd2;

    // Cylinder axes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Side codes
    localparam logic [1:0] SIDE_SOLID = 2'd0;
    localparam logic [1:0] SIDE_FLUID = 2'd1;
    localparam logic [1:0] SIDE_DEGEN = 2'd2;

    typedef struct packed {
        logic [1:0]       side;
        logic             use_root;   // normals come from the root lanes
        logic [2:0]       neg;        // per-lane sign of the normal
        logic [NRM_W-1:0] fix_x;
        logic [NRM_W-1:0] fix_y;
        logic [NRM_W-1:0] fix_z;
    } meta_t;

endpackage

/* src/lpsc_front.sv */
module lpsc_front
    import lpsc_pkg::*;
#(
    parameter int MAX_GRID         = MAX_GRID_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_DEF,
    parameter int RW               = SQ_W + 2 * NORMAL_FRAC_BITS + 2
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [GRID_W-1:0]       grid_x,
    input  logic [GRID_W-1:0]       grid_y,
    input  logic [GRID_W-1:0]       grid_z,
    input  logic                    wall_along_z,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [1:0]              shape_kind,
    input  logic signed [RAD_W-1:0] radius,
    input  logic [1:0]              cyl_axis,
    output logic [SW-1:0]           s_out,
    output logic [2:0][RW-1:0]      r_out,
    output meta_t                   meta_out
);

    localparam logic [CW-1:0]    GMAX   = CW'(MAX_GRID);
    localparam logic [NRM_W-1:0] ONE_N  = NRM_W'(64'd1 << NORMAL_FRAC_BITS);
    localparam logic [NRM_W-1:0] MONE_N = NRM_W'(0) - ONE_N;
    localparam int               LW     = SW + 2 * RADIUS_FRAC_BITS;

    // Clamp grid sizes and form centres in half-lattice units
    logic [CW-1:0]      gxc, gyc, gzc;
    logic signed [14:0] cx, cy, lz, cz, dxw, dyw, dzw;
    logic signed [DW-1:0] dx0, dy0, dz0;

    always_comb begin
        gxc = ({2'b0, grid_x} > GMAX) ? GMAX : {2'b0, grid_x};
        gyc = ({2'b0, grid_y} > GMAX) ? GMAX : {2'b0, grid_y};
        gzc = ({2'b0, grid_z} > GMAX) ? GMAX : {2'b0, grid_z};
        cx  = $signed({2'b0, gxc}) - 15'sd1;
        cy  = $signed({2'b0, gyc}) - 15'sd1;
        lz  = $signed({2'b0, gzc}) - $signed({14'b0, wall_along_z});
        cz  = (shape_kind == KIND_CHAN) ? (lz - 15'sd1) : lz;
        dxw = 15'(pos_x) - cx;
        dyw = 15'(pos_y) - cy;
        dzw = 15'(pos_z) - cz;
        dx0 = dxw[DW-1:0];
        dy0 = dyw[DW-1:0];
        dz0 = dzw[DW-1:0];
        // drop the axis component of a cylinder
        if (shape_kind == KIND_CYL) begin
            if (cyl_axis == AXIS_X) dx0 = '0;
            if (cyl_axis == AXIS_Y) dy0 = '0;
            if (cyl_axis == AXIS_Z) dz0 = '0;
        end
    end

    // Stage 1: offsets
    logic signed [DW-1:0]    dx1_reg, dy1_reg, dz1_reg;
    logic [1:0]              kind1_reg, axis1_reg;
    logic signed [RAD_W-1:0] rad1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg   <= dx0;
            dy1_reg   <= dy0;
            dz1_reg   <= dz0;
            kind1_reg <= shape_kind;
            axis1_reg <= cyl_axis;
            rad1_reg  <= radius;
        end
    end

    // Magnitudes, channel tests and channel normal
    logic [DW-1:0]    nx1, ny1, nz1;
    logic [AW-1:0]    ax, ay, az;
    logic [RAD_W-1:0] r_abs;
    logic [31:0]      chl_y, chl_z, chr;
    logic             ch_ok;
    logic [NRM_W-1:0] cfy, cfz;

    always_comb begin
        nx1   = DW'(0) - dx1_reg;
        ny1   = DW'(0) - dy1_reg;
        nz1   = DW'(0) - dz1_reg;
        ax    = dx1_reg[DW-1] ? nx1[AW-1:0] : dx1_reg[AW-1:0];
        ay    = dy1_reg[DW-1] ? ny1[AW-1:0] : dy1_reg[AW-1:0];
        az    = dz1_reg[DW-1] ? nz1[AW-1:0] : dz1_reg[AW-1:0];
        r_abs = rad1_reg[RAD_W-1] ? (RAD_W'(0) - rad1_reg) : rad1_reg;
        chl_y = 32'(ay) << RADIUS_FRAC_BITS;
        chl_z = 32'(az) << RADIUS_FRAC_BITS;
        chr   = 32'({r_abs, 1'b0});
        ch_ok = !rad1_reg[RAD_W-1] && (chl_y <= chr) && (chl_z <= chr);
        cfy   = '0;
        cfz   = '0;
        if (ay < az) begin
            cfz = (!dz1_reg[DW-1] && (dz1_reg != '0)) ? MONE_N : ONE_N;
        end else begin
            cfy = (!dy1_reg[DW-1] && (dy1_reg != '0)) ? MONE_N : ONE_N;
        end
    end

    // Stage 2: squares
    logic [2:0][SQ_W-1:0] sq2_reg;
    logic [R2_W-1:0]      r2_reg;
    logic [1:0]           kind2_reg, axis2_reg;
    logic                 rzero2_reg, cav2_reg, chok2_reg;
    logic [2:0]           neg2_reg;
    logic [NRM_W-1:0]     cfy2_reg, cfz2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq2_reg[0] <= SQ_W'(ax) * SQ_W'(ax);
            sq2_reg[1] <= SQ_W'(ay) * SQ_W'(ay);
            sq2_reg[2] <= SQ_W'(az) * SQ_W'(az);
            r2_reg     <= R2_W'(r_abs) * R2_W'(r_abs);
            kind2_reg  <= kind1_reg;
            axis2_reg  <= axis1_reg;
            rzero2_reg <= (rad1_reg == '0);
            cav2_reg   <= rad1_reg[RAD_W-1];
            chok2_reg  <= ch_ok;
            neg2_reg   <= {dz1_reg[DW-1], dy1_reg[DW-1], dx1_reg[DW-1]}
                          ^ {3{rad1_reg[RAD_W-1]}};
            cfy2_reg   <= cfy;
            cfz2_reg   <= cfz;
        end
    end

    // Distance sum, inside tests and side decision
    logic [SW-1:0] s_sum;
    logic [LW-1:0] lhs, rhs;
    logic          in_ball, in_tube;
    meta_t         meta_n;

    always_comb begin
        s_sum   = SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);
        lhs     = LW'(s_sum) << (2 * RADIUS_FRAC_BITS);
        rhs     = LW'(r2_reg) << 2;
        in_ball = lhs < rhs;
        in_tube = lhs <= rhs;
        meta_n          = '0;
        meta_n.neg      = neg2_reg;
        unique case (kind2_reg)
            KIND_CHAN: begin
                meta_n.side  = chok2_reg ? SIDE_FLUID : SIDE_SOLID;
                meta_n.fix_y = cfy2_reg;
                meta_n.fix_z = cfz2_reg;
            end
            KIND_CYL: begin
                if (axis2_reg == AXIS_NONE) begin
                    meta_n.side = SIDE_FLUID;
                end else begin
                    meta_n.side     = (in_tube == cav2_reg) ? SIDE_FLUID : SIDE_SOLID;
                    meta_n.use_root = (s_sum != '0);
                end
            end
            default: begin
                if (rzero2_reg) begin
                    meta_n.side = SIDE_DEGEN;
                end else begin
                    meta_n.side     = (in_ball != cav2_reg) ? SIDE_SOLID : SIDE_FLUID;
                    meta_n.use_root = (s_sum != '0);
                end
            end
        endcase
    end

    // Stage 3: sum and scaled squares for the root lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            s_out    <= s_sum;
            r_out[0] <= RW'(sq2_reg[0]) << (2 * NORMAL_FRAC_BITS + 2);
            r_out[1] <= RW'(sq2_reg[1]) << (2 * NORMAL_FRAC_BITS + 2);
            r_out[2] <= RW'(sq2_reg[2]) << (2 * NORMAL_FRAC_BITS + 2);
            meta_out <= meta_n;
        end
    end

endmodule

/* src/lpsc_norm.sv */
module lpsc_norm
    import lpsc_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF,
    parameter int RW               = SQ_W + 2 * NORMAL_FRAC_BITS + 2
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [SW-1:0]                 s_in,
    input  logic [2:0][RW-1:0]            r_in,
    input  meta_t                         meta_in,
    output logic [2:0][NORMAL_FRAC_BITS:0] q_out,
    output meta_t                         meta_out
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int PW = SW + 2 * F + 6;

    // Per stage: P = (2q-1)^2 * s, Q = (2q-1) * s, q = bits found so far
    logic signed [PW-1:0] p_reg  [0:F][0:2];
    logic signed [PW-1:0] qv_reg [0:F][0:2];
    logic [F:0]           qq_reg [0:F][0:2];
    logic [SW-1:0]        s_reg  [0:F];
    logic [RW-1:0]        r_reg  [0:F][0:2];
    meta_t                m_reg  [0:F];

    logic signed [PW-1:0] p_i   [0:F][0:2];
    logic signed [PW-1:0] qv_i  [0:F][0:2];
    logic [F:0]           qq_i  [0:F][0:2];
    logic [RW-1:0]        r_i   [0:F][0:2];
    logic [SW-1:0]        s_i   [0:F];
    meta_t                m_i   [0:F];
    logic signed [PW-1:0] trial [0:F][0:2];
    logic                 take  [0:F][0:2];

    // Try one more quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k <= F; k++) begin
            s_i[k] = (k == 0) ? s_in : s_reg[k-1];
            m_i[k] = (k == 0) ? meta_in : m_reg[k-1];
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    p_i[k][l]  = $signed(PW'(s_in));
                    qv_i[k][l] = -$signed(PW'(s_in));
                    qq_i[k][l] = '0;
                    r_i[k][l]  = r_in[l];
                end else begin
                    p_i[k][l]  = p_reg[k-1][l];
                    qv_i[k][l] = qv_reg[k-1][l];
                    qq_i[k][l] = qq_reg[k-1][l];
                    r_i[k][l]  = r_reg[k-1][l];
                end
                trial[k][l] = p_i[k][l] + (qv_i[k][l] <<< (F - k + 2))
                              + ($signed(PW'(s_i[k])) <<< (2 * (F - k) + 2));
                take[k][l]  = trial[k][l] <= $signed(PW'(r_i[k][l]));
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= F; k++) begin
                s_reg[k] <= s_i[k];
                m_reg[k] <= m_i[k];
                for (int l = 0; l < 3; l++) begin
                    r_reg[k][l] <= r_i[k][l];
                    if (take[k][l]) begin
                        p_reg[k][l]  <= trial[k][l];
                        qv_reg[k][l] <= qv_i[k][l] + ($signed(PW'(s_i[k])) <<< (F - k + 1));
                        qq_reg[k][l] <= qq_i[k][l] | ((F + 1)'(1) << (F - k));
                    end else begin
                        p_reg[k][l]  <= p_i[k][l];
                        qv_reg[k][l] <= qv_i[k][l];
                        qq_reg[k][l] <= qq_i[k][l];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q_out[l] = qq_reg[F][l];
        end
        meta_out = m_reg[F];
    end

endmodule

/* src/lattice_point_shape_classifier.sv */
// Classifies one lattice point per cycle (while not stalled) against a centred
// sphere, cylinder or square y-z channel and returns its side and unit surface
// normal (signed Q1.14 by default; zero where none is defined). A new word is
// taken every cycle while the skid register is empty. Results pass through
// three front stages (offsets, squares, distance sum), one square-root/divide
// stage per normal bit in each of three lanes, and the output register. A skid
// register lets one more word in while a result waits. Grid registers are written
// through the cfg channel, which is always ready; write it only while idle.
module lattice_point_shape_classifier
    import lpsc_pkg::*;
#(
    parameter int MAX_GRID         = MAX_GRID_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pos_x, pos_y, pos_z, radius, zero fill
    input  logic [3:0]  s_tuser,   // shape_kind, cyl_axis
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic [1:0]  m_tuser    // side
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int RW = SQ_W + 2 * F + 2;
    localparam int NP = F + 4;
    localparam int OW = (F + 2 > NRM_W) ? F + 2 : NRM_W;

    // Configuration registers
    logic [GRID_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic              wall_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_x_reg <= GRID_RESET;
            grid_y_reg <= GRID_RESET;
            grid_z_reg <= GRID_RESET;
            wall_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_GRID_X: grid_x_reg <= cfg_data;
                REG_GRID_Y: grid_y_reg <= cfg_data;
                REG_GRID_Z: grid_z_reg <= cfg_data;
                REG_WALL_Z: wall_reg   <= cfg_data[0];
                default:    wall_reg   <= wall_reg;
            endcase
        end
    end

    // Pipeline advance: hold everything while the skid word is occupied
    logic          skid_v_reg;
    logic          adv;
    logic [NP-1:0] v_reg;

    assign adv      = !skid_v_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NP-2:0], s_tvalid};
        end
    end

    logic [SW-1:0]      s_w;
    logic [2:0][RW-1:0] r_w;
    meta_t              meta_f, meta_o;
    logic [2:0][F:0]    q_w;

    lpsc_front #(
        .MAX_GRID         (MAX_GRID),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
        .RW               (RW)
    ) u_front (
        .aclk         (aclk),
        .en           (adv),
        .grid_x       (grid_x_reg),
        .grid_y       (grid_y_reg),
        .grid_z       (grid_z_reg),
        .wall_along_z (wall_reg),
        .pos_x        ($signed(s_tdata[12:0])),
        .pos_y        ($signed(s_tdata[25:13])),
        .pos_z        ($signed(s_tdata[38:26])),
        .shape_kind   (s_tuser[1:0]),
        .radius       ($signed(s_tdata[53:39])),
        .cyl_axis     (s_tuser[3:2]),
        .s_out        (s_w),
        .r_out        (r_w),
        .meta_out     (meta_f)
    );

    lpsc_norm #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .RW               (RW)
    ) u_norm (
        .aclk     (aclk),
        .en       (adv),
        .s_in     (s_w),
        .r_in     (r_w),
        .meta_in  (meta_f),
        .q_out    (q_w),
        .meta_out (meta_o)
    );

    // Apply sign and pick root or fixed normals
    logic [OW-1:0]        qe   [0:2];
    logic [OW-1:0]        qs   [0:2];
    logic [2:0][NRM_W-1:0] nrm;
    logic [47:0]          item_data;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qe[l] = OW'(q_w[l]);
            qs[l] = meta_o.neg[l] ? (OW'(0) - qe[l]) : qe[l];
        end
        nrm[0] = meta_o.use_root ? qs[0][NRM_W-1:0] : meta_o.fix_x;
        nrm[1] = meta_o.use_root ? qs[1][NRM_W-1:0] : meta_o.fix_y;
        nrm[2] = meta_o.use_root ? qs[2][NRM_W-1:0] : meta_o.fix_z;
        item_data = {nrm[2], nrm[1], nrm[0]};
    end

    // Output register and skid word
    logic [47:0] skid_data_reg;
    logic [1:0]  skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid   <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (v_reg[NP-1]) begin
            if (m_tvalid && !m_tready) begin
                skid_v_reg <= 1'b1;
            end else begin
                m_tvalid <= 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                m_tdata <= skid_data_reg;
                m_tuser <= skid_user_reg;
            end
        end else if (v_reg[NP-1]) begin
            if (m_tvalid && !m_tready) begin
                skid_data_reg <= item_data;
                skid_user_reg <= meta_o.side;
            end else begin
                m_tdata <= item_data;
                m_tuser <= meta_o.side;
            end
        end
    end

endmodule

/* src/lpsc_checker.sv */
module lpsc_checker
    import lpsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Side code is never the unused value
    a_side_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == SIDE_SOLID || m_tuser == SIDE_FLUID
                      || m_tuser == SIDE_DEGEN))
        else $error("bad side code");

    // Degenerate sphere carries a zero normal
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SIDE_DEGEN) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero normal");

    // Nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Config channel never stalls
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind lattice_point_shape_classifier lpsc_checker u_lpsc_checker (.*);
